// ===== design/ffsa_pkg.sv =====
package ffsa_pkg;

   // default geometry
   localparam int MEM_SLOTS_DEF    = 256;
   localparam int FILE_ENTRIES_DEF = 64;

   // field widths at the ports
   localparam int KIND_W   = 3;
   localparam int SLOT_W   = 8;
   localparam int LEN_W    = 9;
   localparam int FID_W    = 6;
   localparam int STATUS_W = 2;
   localparam int RFILE_W  = 7;
   localparam int RSLOT_W  = 9;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = 9;

   localparam logic [SIZE_W-1:0] MEM_SIZE_RST = 9'd256;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PLACE_FIRST = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PLACE_AT    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_SLOT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_FILE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OWNER       = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CHECK       = 3'd5;
   localparam logic [KIND_W-1:0] KIND_FIND        = 3'd6;
   localparam logic [KIND_W-1:0] KIND_FORMAT      = 3'd7;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

endpackage

// ===== design/ffsa_slot_map.sv =====
module ffsa_slot_map #(
   parameter int MEM_SLOTS    = ffsa_pkg::MEM_SLOTS_DEF,
   parameter int FILE_ENTRIES = ffsa_pkg::FILE_ENTRIES_DEF,
   localparam int AW = $clog2(MEM_SLOTS),
   localparam int FW = $clog2(FILE_ENTRIES)
) (
   input  logic          clock,
   input  logic [AW-1:0] rd_addr,
   input  logic [FW-1:0] match_id,
   output logic          rd_used,
   output logic [FW-1:0] rd_owner,
   output logic          rd_hit,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_used,
   input  logic [FW-1:0] wr_owner
);

   // entry = {used, owner}
   logic [FW:0] map_mem [MEM_SLOTS];
   logic [FW:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= {wr_used, wr_owner};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_addr];
   end

   assign rd_used  = rd_data_ff[FW];
   assign rd_owner = rd_data_ff[FW-1:0];
   assign rd_hit   = rd_data_ff[FW] && (rd_data_ff[FW-1:0] == match_id);

endmodule

// ===== design/first_fit_slot_allocator_core.sv =====
// First-fit slot allocator.
//
// Request channel (req_*): one transaction per operation, taken when req_valid
// is high and req_stall is low. Response channel (rsp_*): exactly one
// transaction per request, in order, held stable while rsp_stall is high.
// A finished response sits in the output register, so the next request is
// taken while the previous response still waits for the receiver.
// CSR channel (csr_*): writes mem_size when csr_valid and csr_ready are high;
// it is ready only between operations and takes priority over a request.
//
// Passes run at one slot-map read per cycle in the scan loop. An owner,
// remove-by-slot or remove-file lookup is a single read and its evaluation,
// plus a sweep of the effective size for a removal; find and check scan up
// to size slots; place first fit scans up to size slots, searches the file
// table, then fills the run; place at searches the file table and fills the
// run; format clears both memories. One operation is in flight at a time.
// Reset runs a clearing pass over both memories with req_stall and csr_ready
// held off. A mem_size write runs a trim pass that frees the slots above the
// new size.
module first_fit_slot_allocator_core #(
   parameter int MEM_SLOTS    = ffsa_pkg::MEM_SLOTS_DEF,
   parameter int FILE_ENTRIES = ffsa_pkg::FILE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ffsa_pkg::KIND_W-1:0]         req_kind,
   input  logic [ffsa_pkg::SLOT_W-1:0]         req_slot,
   input  logic [ffsa_pkg::LEN_W-1:0]          req_length,
   input  logic [ffsa_pkg::FID_W-1:0]          req_file_id,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [ffsa_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ffsa_pkg::RFILE_W-1:0] rsp_result_file,
   output logic signed [ffsa_pkg::RSLOT_W-1:0] rsp_result_slot,
   output logic                                rsp_formatted,
   output logic [ffsa_pkg::COUNT_W-1:0]        rsp_file_count,
   // csr write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ffsa_pkg::SIZE_W-1:0]         csr_mem_size
);

   localparam int AW    = $clog2(MEM_SLOTS);
   localparam int FW    = $clog2(FILE_ENTRIES);
   localparam int CW    = $clog2(FILE_ENTRIES + 1);
   localparam int XW    = (AW > FW) ? AW : FW;
   // index arithmetic: slot + length, counters up to the clearing length
   localparam int IW    = ((XW > ffsa_pkg::LEN_W) ? XW : ffsa_pkg::LEN_W) + 2;
   localparam int CLR_N = (MEM_SLOTS > FILE_ENTRIES) ? MEM_SLOTS : FILE_ENTRIES;

   localparam logic [IW-1:0] SLOTS_I  = IW'(MEM_SLOTS);
   localparam logic [IW-1:0] FILES_I  = IW'(FILE_ENTRIES);
   localparam logic [IW-1:0] CLR_LAST = IW'(CLR_N - 1);
   localparam logic [ffsa_pkg::RFILE_W-1:0] NO_FILE = '1;
   localparam logic [ffsa_pkg::RSLOT_W-1:0] NO_SLOT = '1;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,   // clearing pass (reset / format)
      ST_IDLE  = 8'b0000_0010,
      ST_RD    = 8'b0000_0100,   // single lookup read
      ST_EVAL  = 8'b0000_1000,   // act on lookup data
      ST_SCAN  = 8'b0001_0000,   // streaming pass over the slot map
      ST_FSCAN = 8'b0010_0000,   // search for lowest free file id
      ST_WRITE = 8'b0100_0000,   // fill / trim run of slots
      ST_OUT   = 8'b1000_0000    // hand result to output register
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [ffsa_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [ffsa_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [ffsa_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [ffsa_pkg::FID_W-1:0]  fid_ff, fid_in;

   // architectural state
   logic [ffsa_pkg::SIZE_W-1:0] mem_size_ff, mem_size_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        fmt_ff, fmt_in;

   // scan / write machinery
   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] lim_ff, lim_in;
   logic          p_vld_ff, p_vld_in;
   logic [IW-1:0] p_idx_ff, p_idx_in;
   logic [IW-1:0] run_ff, run_in;
   logic [IW-1:0] start_ff, start_in;
   logic [FW-1:0] id_ff, id_in;
   logic          wval_ff, wval_in;
   logic          resp_pend_ff, resp_pend_in;

   // working result
   logic                          res_ok_ff, res_ok_in;
   logic [ffsa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ffsa_pkg::RFILE_W-1:0]  res_file_ff, res_file_in;
   logic [ffsa_pkg::RSLOT_W-1:0]  res_slot_ff, res_slot_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [ffsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ffsa_pkg::RFILE_W-1:0]  rsp_file_ff, rsp_file_in;
   logic [ffsa_pkg::RSLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                          rsp_fmt_ff, rsp_fmt_in;
   logic [ffsa_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // slot map port
   logic [AW-1:0] map_rd_addr;
   logic          map_used;
   logic [FW-1:0] map_owner;
   logic          map_hit;
   logic          map_wr_en;
   logic [AW-1:0] map_wr_addr;
   logic          map_wr_used;
   logic [FW-1:0] map_wr_owner;

   // file table: one in-use bit per id
   logic          file_mem [FILE_ENTRIES];
   logic          file_rd_ff;
   logic [FW-1:0] file_rd_addr;
   logic          file_wr_en;
   logic [FW-1:0] file_wr_addr;
   logic          file_wr_used;

   // derived values
   logic [IW-1:0] size;        // effective size
   logic [IW-1:0] csr_size;    // effective size after a csr write
   logic [IW-1:0] req_end;     // req_slot + req_length
   logic [IW-1:0] chk_end;     // slot_ff + len_ff
   logic [IW-1:0] place_end;   // start_ff + len_ff
   logic [IW-1:0] p_next;
   logic [IW-1:0] run_next;
   logic          last;

   assign size     = (IW'(mem_size_ff) > SLOTS_I) ? SLOTS_I : IW'(mem_size_ff);
   assign csr_size = (IW'(csr_mem_size) > SLOTS_I) ? SLOTS_I : IW'(csr_mem_size);
   assign req_end   = IW'(req_slot) + IW'(req_length);
   assign chk_end   = IW'(slot_ff) + IW'(len_ff);
   assign place_end = start_ff + IW'(len_ff);
   assign p_next    = p_idx_ff + 1'b1;
   assign run_next  = run_ff + 1'b1;
   assign last      = (p_next == lim_ff);

   assign map_rd_addr  = (state_ff == ST_RD) ? AW'(slot_ff) : scan_ff[AW-1:0];
   assign file_rd_addr = (state_ff == ST_RD) ? FW'(fid_ff) : scan_ff[FW-1:0];

   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);

   ffsa_slot_map #(
      .MEM_SLOTS    (MEM_SLOTS),
      .FILE_ENTRIES (FILE_ENTRIES)
   ) u_slot_map (
      .clock    (clock),
      .rd_addr  (map_rd_addr),
      .match_id (id_ff),
      .rd_used  (map_used),
      .rd_owner (map_owner),
      .rd_hit   (map_hit),
      .wr_en    (map_wr_en),
      .wr_addr  (map_wr_addr),
      .wr_used  (map_wr_used),
      .wr_owner (map_wr_owner)
   );

   always_ff @(posedge clock) begin
      if (file_wr_en) begin
         file_mem[file_wr_addr] <= file_wr_used;
      end
   end

   always_ff @(posedge clock) begin
      file_rd_ff <= file_mem[file_rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      slot_in       = slot_ff;
      len_in        = len_ff;
      fid_in        = fid_ff;
      mem_size_in   = mem_size_ff;
      count_in      = count_ff;
      fmt_in        = fmt_ff;
      scan_in       = scan_ff;
      lim_in        = lim_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = scan_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      id_in         = id_ff;
      wval_in       = wval_ff;
      resp_pend_in  = resp_pend_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      res_file_in   = res_file_ff;
      res_slot_in   = res_slot_ff;
      // response leaves the output register when taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_file_in   = rsp_file_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fmt_in    = rsp_fmt_ff;
      rsp_count_in  = rsp_count_ff;
      map_wr_en     = 1'b0;
      map_wr_addr   = p_idx_ff[AW-1:0];
      map_wr_used   = 1'b0;
      map_wr_owner  = id_ff;
      file_wr_en    = 1'b0;
      file_wr_addr  = FW'(fid_ff);
      file_wr_used  = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            map_wr_en    = (scan_ff < SLOTS_I);
            map_wr_addr  = scan_ff[AW-1:0];
            file_wr_en   = (scan_ff < FILES_I);
            file_wr_addr = scan_ff[FW-1:0];
            scan_in      = scan_ff + 1'b1;
            if (scan_ff == CLR_LAST) begin
               state_in = resp_pend_ff ? ST_OUT : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (csr_valid) begin
               // new size, then free everything above it
               mem_size_in  = csr_mem_size;
               scan_in      = csr_size;
               lim_in       = SLOTS_I;
               wval_in      = 1'b0;
               resp_pend_in = 1'b0;
               state_in     = ST_WRITE;
            end else if (req_valid) begin
               kind_in       = req_kind;
               slot_in       = req_slot;
               len_in        = req_length;
               fid_in        = req_file_id;
               res_ok_in     = 1'b0;
               res_status_in = ffsa_pkg::STATUS_OK;
               res_file_in   = NO_FILE;
               res_slot_in   = NO_SLOT;
               resp_pend_in  = 1'b1;
               scan_in       = '0;
               run_in        = '0;
               lim_in        = size;
               case (req_kind)
                  ffsa_pkg::KIND_PLACE_FIRST: begin
                     if (size == '0) begin
                        res_status_in = ffsa_pkg::STATUS_RANGE;
                        state_in      = ST_OUT;
                     end else if (req_length == '0) begin
                        // empty file fits at slot 0
                        start_in = '0;
                        lim_in   = FILES_I;
                        state_in = ST_FSCAN;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ffsa_pkg::KIND_PLACE_AT: begin
                     start_in = IW'(req_slot);
                     lim_in   = FILES_I;
                     state_in = ST_FSCAN;
                  end
                  ffsa_pkg::KIND_REMOVE_SLOT: begin
                     if (IW'(req_slot) >= size) begin
                        res_status_in = ffsa_pkg::STATUS_RANGE;
                        state_in      = ST_OUT;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  ffsa_pkg::KIND_REMOVE_FILE: begin
                     if (IW'(req_file_id) >= FILES_I) begin
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  ffsa_pkg::KIND_OWNER: begin
                     if (IW'(req_slot) >= size) begin
                        res_status_in = ffsa_pkg::STATUS_RANGE;
                        state_in      = ST_OUT;
                     end else begin
                        state_in = ST_RD;
                     end
                  end
                  ffsa_pkg::KIND_CHECK: begin
                     res_slot_in = ffsa_pkg::RSLOT_W'(req_slot);
                     if (req_length == '0) begin
                        res_ok_in = 1'b1;
                        state_in  = ST_OUT;
                     end else if (IW'(req_slot) >= size) begin
                        res_status_in = ffsa_pkg::STATUS_RANGE;
                        state_in      = ST_OUT;
                     end else begin
                        scan_in  = IW'(req_slot);
                        lim_in   = (req_end < size) ? req_end : size;
                        state_in = ST_SCAN;
                     end
                  end
                  ffsa_pkg::KIND_FIND: begin
                     id_in = FW'(req_file_id);
                     // an id past the table can own no slot
                     if ((size == '0) || (IW'(req_file_id) >= FILES_I)) begin
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ffsa_pkg::KIND_FORMAT: begin
                     res_ok_in = 1'b1;
                     count_in  = '0;
                     fmt_in    = 1'b1;
                     state_in  = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_RD: begin
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            state_in = ST_OUT;
            case (kind_ff)
               ffsa_pkg::KIND_REMOVE_SLOT: begin
                  if (map_used) begin
                     id_in        = map_owner;
                     file_wr_en   = 1'b1;
                     file_wr_addr = map_owner;
                     count_in     = count_ff - 1'b1;
                     if (count_ff == CW'(1)) begin
                        fmt_in = 1'b1;
                     end
                     res_ok_in   = 1'b1;
                     res_file_in = ffsa_pkg::RFILE_W'(map_owner);
                     res_slot_in = ffsa_pkg::RSLOT_W'(slot_ff);
                     scan_in     = '0;
                     lim_in      = size;
                     state_in    = ST_SCAN;
                  end
               end
               ffsa_pkg::KIND_REMOVE_FILE: begin
                  if (file_rd_ff) begin
                     id_in      = FW'(fid_ff);
                     file_wr_en = 1'b1;
                     count_in   = count_ff - 1'b1;
                     if (count_ff == CW'(1)) begin
                        fmt_in = 1'b1;
                     end
                     res_ok_in   = 1'b1;
                     res_file_in = ffsa_pkg::RFILE_W'(fid_ff);
                     scan_in     = '0;
                     lim_in      = size;
                     if (size != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
               end
               ffsa_pkg::KIND_OWNER: begin
                  if (map_used) begin
                     res_ok_in   = 1'b1;
                     res_file_in = ffsa_pkg::RFILE_W'(map_owner);
                     res_slot_in = ffsa_pkg::RSLOT_W'(slot_ff);
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SCAN: begin
            // map data of p_idx_ff is valid in this cycle
            if (p_vld_ff) begin
               case (kind_ff)
                  ffsa_pkg::KIND_PLACE_FIRST: begin
                     if (!map_used) begin
                        run_in = run_next;
                        if (run_next == IW'(len_ff)) begin
                           start_in = p_next - IW'(len_ff);
                           scan_in  = '0;
                           lim_in   = FILES_I;
                           state_in = ST_FSCAN;
                        end else if (last) begin
                           res_status_in = ffsa_pkg::STATUS_RANGE;
                           state_in      = ST_OUT;
                        end
                     end else begin
                        run_in = '0;
                        if (last) begin
                           res_status_in = ffsa_pkg::STATUS_RANGE;
                           state_in      = ST_OUT;
                        end
                     end
                  end
                  ffsa_pkg::KIND_CHECK: begin
                     if (map_used) begin
                        res_status_in = ffsa_pkg::STATUS_OVERLAP;
                        state_in      = ST_OUT;
                     end else if (last) begin
                        // run hits the end of the size before its length
                        if (chk_end > size) begin
                           res_status_in = ffsa_pkg::STATUS_RANGE;
                        end else begin
                           res_ok_in = 1'b1;
                        end
                        state_in = ST_OUT;
                     end
                  end
                  ffsa_pkg::KIND_FIND: begin
                     if (map_hit) begin
                        res_ok_in   = 1'b1;
                        res_file_in = ffsa_pkg::RFILE_W'(id_ff);
                        res_slot_in = ffsa_pkg::RSLOT_W'(p_idx_ff);
                        state_in    = ST_OUT;
                     end else if (last) begin
                        state_in = ST_OUT;
                     end
                  end
                  default: begin
                     // removal sweep: free every slot of id_ff
                     if (map_hit) begin
                        map_wr_en = 1'b1;
                     end
                     if (last) begin
                        state_in = ST_OUT;
                     end
                  end
               endcase
            end
         end

         ST_FSCAN: begin
            if (p_vld_ff) begin
               if (!file_rd_ff) begin
                  // lowest free id: claim it, then fill the run
                  id_in        = p_idx_ff[FW-1:0];
                  file_wr_en   = 1'b1;
                  file_wr_addr = p_idx_ff[FW-1:0];
                  file_wr_used = 1'b1;
                  count_in     = count_ff + 1'b1;
                  res_ok_in    = 1'b1;
                  res_file_in  = ffsa_pkg::RFILE_W'(p_idx_ff[FW-1:0]);
                  res_slot_in  = ffsa_pkg::RSLOT_W'(start_ff);
                  if ((len_ff != '0) && (place_end > size)) begin
                     res_status_in = ffsa_pkg::STATUS_RANGE;
                  end else begin
                     res_status_in = ffsa_pkg::STATUS_OK;
                  end
                  scan_in  = start_ff;
                  lim_in   = (place_end < size) ? place_end : size;
                  wval_in  = 1'b1;
                  state_in = ST_WRITE;
               end else if (last) begin
                  res_status_in = ffsa_pkg::STATUS_FULL;
                  res_slot_in   = ffsa_pkg::RSLOT_W'(start_ff);
                  state_in      = ST_OUT;
               end
            end
         end

         ST_WRITE: begin
            if (scan_ff < lim_ff) begin
               map_wr_en   = 1'b1;
               map_wr_addr = scan_ff[AW-1:0];
               map_wr_used = wval_ff;
               scan_in     = scan_ff + 1'b1;
            end else begin
               state_in = resp_pend_ff ? ST_OUT : ST_IDLE;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = res_ok_ff;
               rsp_status_in = res_status_ff;
               rsp_file_in   = res_file_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_fmt_in    = fmt_ff;
               rsp_count_in  = ffsa_pkg::COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // issue one streaming read per cycle while the pass runs
      if (((state_ff == ST_SCAN) || (state_ff == ST_FSCAN)) && (state_in == state_ff)
          && (scan_ff < lim_ff)) begin
         p_vld_in = 1'b1;
         p_idx_in = scan_ff;
         scan_in  = scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         resp_pend_ff <= 1'b0;
         p_vld_ff     <= 1'b0;
         mem_size_ff  <= ffsa_pkg::MEM_SIZE_RST;
         count_ff     <= '0;
         fmt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         resp_pend_ff <= resp_pend_in;
         p_vld_ff     <= p_vld_in;
         mem_size_ff  <= mem_size_in;
         count_ff     <= count_in;
         fmt_ff       <= fmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      slot_ff       <= slot_in;
      len_ff        <= len_in;
      fid_ff        <= fid_in;
      lim_ff        <= lim_in;
      p_idx_ff      <= p_idx_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      id_ff         <= id_in;
      wval_ff       <= wval_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      res_file_ff   <= res_file_in;
      res_slot_ff   <= res_slot_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_file_ff   <= rsp_file_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fmt_ff    <= rsp_fmt_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_file = rsp_file_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_formatted   = rsp_fmt_ff;
   assign rsp_file_count  = rsp_count_ff;

endmodule

// ===== tb/tb_first_fit_slot_allocator_core.sv =====
module tb_first_fit_slot_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ffsa_pkg::*;

   localparam int MEM_SLOTS    = MEM_SLOTS_DEF;
   localparam int FILE_ENTRIES = FILE_ENTRIES_DEF;

   // Memory sizes, one per phase. Phase 0 runs the directed list; the rest are
   // random. 511 exercises saturation, 0 and 1 the empty and tiny maps.
   localparam int N_PHASES = 13;
   localparam int SIZE_PLAN [0:N_PHASES-1] =
      '{256, 511, 0, 255, 1, 16, 40, 256, 5, 100, 3, 64, 128};
   localparam int FILL_PHASE       = 5;   // id table filled on a small map
   localparam int HOLD_PHASE       = 7;   // id table filled, receiver holds off
   localparam int RANDOM_PER_PHASE = 90;
   localparam int HOLD_CYCLES      = 1200; // longer than the slowest operation
   localparam int SETTLE_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT   = 5000;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  length;
      logic [FID_W-1:0]  file_id;
   } alloc_op_t;

   typedef struct {
      logic                       ok;
      logic [STATUS_W-1:0]        status;
      logic signed [RFILE_W-1:0]  rfile;
      logic signed [RSLOT_W-1:0]  rslot;
      logic                       formatted;
      logic [COUNT_W-1:0]         count;
   } alloc_rsp_t;

   // ---------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind    = '0;
   logic [SLOT_W-1:0]    req_slot    = '0;
   logic [LEN_W-1:0]     req_length  = '0;
   logic [FID_W-1:0]     req_file_id = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_ok;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [RFILE_W-1:0]  rsp_result_file;
   logic signed [RSLOT_W-1:0]  rsp_result_slot;
   logic                       rsp_formatted;
   logic [COUNT_W-1:0]         rsp_file_count;

   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [SIZE_W-1:0]    csr_mem_size = '0;

   first_fit_slot_allocator_core #(
      .MEM_SLOTS    (MEM_SLOTS),
      .FILE_ENTRIES (FILE_ENTRIES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_length      (req_length),
      .req_file_id     (req_file_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_status      (rsp_status),
      .rsp_result_file (rsp_result_file),
      .rsp_result_slot (rsp_result_slot),
      .rsp_formatted   (rsp_formatted),
      .rsp_file_count  (rsp_file_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_mem_size    (csr_mem_size)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   alloc_op_t  pending_ops[$];     // requests not yet driven
   alloc_rsp_t predicted_rsps[$];  // responses owed by the DUT, oldest first
   int         open_ops      = 0;  // queued but not yet answered
   int         phase_eff     = MEM_SLOTS;
   bit         send_gaps_on  = 1'b0;
   bit         rsp_stalls_on = 1'b0;
   bit         hold_wanted   = 1'b0;
   bit         req_took      = 1'b0; // request taken at the last rising edge
   int         err_count     = 0;
   int         quiet_cycles  = 0;

   // run statistics
   int n_reqs = 0, n_placed = 0, n_removed = 0, n_full = 0, n_range = 0, n_overlap = 0;

   // ---------------------------------------------------------------------
   // Allocator shadow: slot map, id table, counters
   // ---------------------------------------------------------------------
   int             eff_size = MEM_SLOTS;
   bit             map_used  [MEM_SLOTS];
   logic [FID_W-1:0] map_owner [MEM_SLOTS];
   bit             id_busy   [FILE_ENTRIES];
   int             ids_open  = 0;
   bit             fmt_flag  = 1'b0;

   // 0 free, 1 overlap, 2 out of range; stops at the first offending slot
   function automatic logic [STATUS_W-1:0] span_status(int start, int len);
      int k;
      for (k = 0; k < len; k++) begin
         if (start + k >= eff_size) return STATUS_RANGE;
         if (map_used[start + k]) return STATUS_OVERLAP;
      end
      return STATUS_OK;
   endfunction

   // lowest free id, or -1 when the table is full
   function automatic int take_id();
      int f;
      for (f = 0; f < FILE_ENTRIES; f++) begin
         if (!id_busy[f]) begin
            id_busy[f] = 1'b1;
            ids_open++;
            return f;
         end
      end
      return -1;
   endfunction

   // writes the owner into the span; returns 1 if part of it fell off the map
   function automatic bit fill_span(int start, int len, int id);
      int k;
      bit dropped;
      dropped = 1'b0;
      for (k = 0; k < len; k++) begin
         if (start + k >= eff_size) begin
            dropped = 1'b1;
         end else begin
            map_used[start + k]  = 1'b1;
            map_owner[start + k] = id;
         end
      end
      return dropped;
   endfunction

   function automatic bit drop_file(int id);
      int i;
      if (!id_busy[id]) return 1'b0;
      id_busy[id] = 1'b0;
      ids_open--;
      for (i = 0; i < eff_size; i++)
         if (map_used[i] && map_owner[i] == id) map_used[i] = 1'b0;
      if (ids_open == 0) fmt_flag = 1'b1;
      return 1'b1;
   endfunction

   // Applies one request to the shadow and returns the response it earns.
   function automatic alloc_rsp_t next_alloc_rsp(alloc_op_t op);
      alloc_rsp_t r;
      int i, first, id, owner;
      r.ok     = 1'b0;
      r.status = STATUS_OK;
      r.rfile  = -1;
      r.rslot  = -1;
      first    = -1;
      case (op.kind)
         KIND_PLACE_FIRST: begin
            for (i = 0; i < eff_size; i++) begin
               if (span_status(i, op.length) == STATUS_OK) begin
                  first = i;
                  break;
               end
            end
            if (first < 0) begin
               r.status = STATUS_RANGE;
            end else begin
               r.rslot = first;
               id = take_id();
               if (id < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  void'(fill_span(first, op.length, id));
                  r.rfile = id;
                  r.ok    = 1'b1;
               end
            end
         end
         KIND_PLACE_AT: begin
            // no overlap check: used slots get the new owner
            r.rslot = {1'b0, op.slot};
            id = take_id();
            if (id < 0) begin
               r.status = STATUS_FULL;
            end else begin
               r.status = fill_span(op.slot, op.length, id) ? STATUS_RANGE : STATUS_OK;
               r.rfile  = id;
               r.ok     = 1'b1;
            end
         end
         KIND_REMOVE_SLOT: begin
            if (op.slot >= eff_size) begin
               r.status = STATUS_RANGE;
            end else if (map_used[op.slot] && id_busy[map_owner[op.slot]]) begin
               owner = map_owner[op.slot];
               if (drop_file(owner)) begin
                  r.ok    = 1'b1;
                  r.rfile = owner;
                  r.rslot = {1'b0, op.slot};
               end
            end
         end
         KIND_REMOVE_FILE: begin
            if (drop_file(op.file_id)) begin
               r.ok    = 1'b1;
               r.rfile = {1'b0, op.file_id};
            end
         end
         KIND_OWNER: begin
            if (op.slot >= eff_size) begin
               r.status = STATUS_RANGE;
            end else if (map_used[op.slot] && id_busy[map_owner[op.slot]]) begin
               r.ok    = 1'b1;
               r.rfile = {1'b0, map_owner[op.slot]};
               r.rslot = {1'b0, op.slot};
            end
         end
         KIND_CHECK: begin
            r.status = span_status(op.slot, op.length);
            r.ok     = (r.status == STATUS_OK);
            r.rslot  = {1'b0, op.slot};
         end
         KIND_FIND: begin
            for (i = 0; i < eff_size; i++) begin
               if (map_used[i] && map_owner[i] == op.file_id) begin
                  r.ok    = 1'b1;
                  r.rfile = {1'b0, op.file_id};
                  r.rslot = i;
                  break;
               end
            end
         end
         KIND_FORMAT: begin
            for (i = 0; i < MEM_SLOTS; i++) begin
               map_used[i]  = 1'b0;
               map_owner[i] = '0;
            end
            for (i = 0; i < FILE_ENTRIES; i++) id_busy[i] = 1'b0;
            ids_open = 0;
            fmt_flag = 1'b1;
            r.ok     = 1'b1;
         end
      endcase
      r.formatted = fmt_flag;
      r.count     = ids_open;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: pulls from pending_ops, changes inputs on falling edges
   // ---------------------------------------------------------------------
   alloc_op_t cur_op;
   int        send_gap = 0;

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_took)) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_ops.size() != 0 && send_gaps_on &&
                      $urandom_range(0, 7) == 0) begin
            // start an idle burst with req_valid held low, this one included
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 14);
         end else if (pending_ops.size() != 0) begin
            cur_op       = pending_ops.pop_front();
            req_kind    <= cur_op.kind;
            req_slot    <= cur_op.slot;
            req_length  <= cur_op.length;
            req_file_id <= cur_op.file_id;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response receiver: random stall bursts, plus one long hold-off that lets
   // the DUT back up into its request port
   // ---------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_wanted) begin
         hold_wanted = 1'b0;
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: samples all three channels on rising edges, predicts and checks
   // ---------------------------------------------------------------------
   task automatic check_field(string name, logic signed [15:0] want,
                              logic signed [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   alloc_op_t  seen_op;
   alloc_rsp_t want_rsp;

   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         // size write: saturate, then free everything past the new top
         if (csr_valid && csr_ready) begin
            eff_size = (csr_mem_size > MEM_SLOTS) ? MEM_SLOTS : int'(csr_mem_size);
            for (int i = eff_size; i < MEM_SLOTS; i++) map_used[i] = 1'b0;
         end

         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsps.size() == 0) begin
               $error("response transaction with no request outstanding");
               err_count++;
            end else begin
               want_rsp = predicted_rsps.pop_front();
               check_field("ok",          want_rsp.ok,        rsp_ok);
               check_field("status",      want_rsp.status,    rsp_status);
               check_field("result_file", want_rsp.rfile,     rsp_result_file);
               check_field("result_slot", want_rsp.rslot,     rsp_result_slot);
               check_field("formatted",   want_rsp.formatted, rsp_formatted);
               check_field("file_count",  want_rsp.count,     rsp_file_count);
               open_ops--;
            end
         end

         if (req_valid && !req_stall) begin
            req_took        = 1'b1;
            seen_op.kind    = req_kind;
            seen_op.slot    = req_slot;
            seen_op.length  = req_length;
            seen_op.file_id = req_file_id;
            want_rsp = next_alloc_rsp(seen_op);
            predicted_rsps.push_back(want_rsp);
            n_reqs++;
            if (want_rsp.ok && (seen_op.kind == KIND_PLACE_FIRST ||
                                seen_op.kind == KIND_PLACE_AT)) n_placed++;
            if (want_rsp.ok && (seen_op.kind == KIND_REMOVE_SLOT ||
                                seen_op.kind == KIND_REMOVE_FILE)) n_removed++;
            if (want_rsp.status == STATUS_FULL)    n_full++;
            if (want_rsp.status == STATUS_RANGE)   n_range++;
            if (want_rsp.status == STATUS_OVERLAP) n_overlap++;
         end
      end
   end

   // watchdog: too long with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles, %0d responses outstanding",
                quiet_cycles, open_ops);
         $display("tb_first_fit_slot_allocator_core failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_op(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                           logic [LEN_W-1:0] l, logic [FID_W-1:0] f);
      alloc_op_t op;
      op.kind    = k;
      op.slot    = s;
      op.length  = l;
      op.file_id = f;
      pending_ops.push_back(op);
      open_ops++;
   endtask

   // Mostly small files packed from slot 0, so queries by slot and low ids
   // usually hit something; fields an operation ignores stay random.
   task automatic queue_random_op();
      logic [KIND_W-1:0] k;
      logic [SLOT_W-1:0] s;
      logic [LEN_W-1:0]  l;
      logic [FID_W-1:0]  f;
      int pick;
      pick = $urandom_range(0, 99);
      if (phase_eff > 0 && $urandom_range(0, 4) != 0)
         s = $urandom_range(0, phase_eff - 1);
      else
         s = $urandom_range(0, 255);
      l = $urandom_range(1, 8);
      f = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 63);
      if (pick < 25) begin
         k = KIND_PLACE_FIRST;
         case ($urandom_range(0, 19))
            0, 1:    l = 0;
            2:       l = $urandom_range(0, 256);
            3, 4, 5: l = $urandom_range(9, 40);
            default: ;
         endcase
      end else if (pick < 35) begin
         k = KIND_PLACE_AT;
         if ($urandom_range(0, 4) == 0) l = $urandom_range(0, 256);
      end else if (pick < 47) begin
         k = KIND_REMOVE_SLOT;
      end else if (pick < 59) begin
         k = KIND_REMOVE_FILE;
      end else if (pick < 71) begin
         k = KIND_OWNER;
      end else if (pick < 85) begin
         k = KIND_CHECK;
         if ($urandom_range(0, 3) == 0) l = $urandom_range(0, 256);
      end else if (pick < 97) begin
         k = KIND_FIND;
      end else begin
         k = KIND_FORMAT;
      end
      queue_op(k, s, l, f);
   endtask

   // Zero/one-length placements until the id table runs out, a place-at on
   // the full table, then free a few ids again.
   task automatic queue_table_fill();
      repeat (FILE_ENTRIES + 2)
         queue_op(KIND_PLACE_FIRST, $urandom, ($urandom_range(0, 3) == 0) ? 1 : 0, $urandom);
      queue_op(KIND_PLACE_AT, 0, 3, $urandom);
      for (int i = 0; i < 8; i++)
         queue_op(KIND_REMOVE_FILE, $urandom, $urandom_range(0, 8), i);
   endtask

   task automatic wait_drained();
      while (open_ops != 0) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         // the size register is only written with nothing in flight
         wait_drained();
         @(negedge clock);
         csr_mem_size <= SIZE_PLAN[p];
         csr_valid    <= 1'b1;
         do @(posedge clock); while (!(csr_valid && csr_ready));

         phase_eff     = (SIZE_PLAN[p] > MEM_SLOTS) ? MEM_SLOTS : SIZE_PLAN[p];
         send_gaps_on  = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (p == HOLD_PHASE) hold_wanted = 1'b1;

         if (p == 0) begin
            // empty store: lookups miss, zero-length check passes
            queue_op(KIND_OWNER,       0,   1,   0);
            queue_op(KIND_REMOVE_FILE, 0,   0,   0);
            queue_op(KIND_REMOVE_SLOT, 5,   0,   0);
            queue_op(KIND_FIND,        0,   0,   63);
            queue_op(KIND_CHECK,       0,   0,   0);
            // zero-length file owns no slots; then a real one; then no room
            queue_op(KIND_PLACE_FIRST, 0,   0,   0);
            queue_op(KIND_PLACE_FIRST, 0,   4,   0);
            queue_op(KIND_PLACE_FIRST, 0,   256, 0);
            // runs off the top of the map: tail dropped, still placed
            queue_op(KIND_PLACE_AT,    250, 10,  0);
            queue_op(KIND_CHECK,       2,   3,   0);
            queue_op(KIND_CHECK,       200, 100, 0);
            queue_op(KIND_CHECK,       10,  5,   0);
            queue_op(KIND_OWNER,       252, 0,   0);
            queue_op(KIND_FIND,        0,   0,   2);
            // overwrite part of file 1 without a check
            queue_op(KIND_PLACE_AT,    1,   2,   0);
            queue_op(KIND_REMOVE_SLOT, 0,   0,   0);
            queue_op(KIND_REMOVE_FILE, 0,   0,   0);
            queue_op(KIND_REMOVE_FILE, 0,   0,   2);
            // last file out sets the formatted flag
            queue_op(KIND_REMOVE_SLOT, 1,   0,   0);
            queue_op(KIND_PLACE_FIRST, 255, 255, 63);
            queue_op(KIND_FORMAT,      0,   0,   0);
            queue_op(KIND_PLACE_AT,    255, 256, 63);
            queue_op(KIND_OWNER,       255, 0,   0);
         end else begin
            if (p == FILL_PHASE || p == HOLD_PHASE) queue_table_fill();
            repeat (RANDOM_PER_PHASE) queue_random_op();
         end

         @(negedge clock);
         csr_valid <= 1'b0;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_rsps.size() != 0) begin
         $error("%0d expected responses never arrived", predicted_rsps.size());
         err_count++;
      end

      $display("Ran %0d requests over %0d map sizes (0 through saturation at 511).",
               n_reqs, N_PHASES);
      $display("Saw %0d placements, %0d removals, %0d full-table, %0d range, %0d overlap.",
               n_placed, n_removed, n_full, n_range, n_overlap);
      if (err_count == 0)
         $display("tb_first_fit_slot_allocator_core passed");
      else
         $display("tb_first_fit_slot_allocator_core failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ffsa_pkg.sv
design/ffsa_slot_map.sv
design/first_fit_slot_allocator_core.sv
tb/tb_first_fit_slot_allocator_core.sv
